@@ rtl/esc_pkg.sv @@
// Shared types, constants and decode functions of the stress correlator.
`timescale 1ns / 1ps

package esc_pkg;

   // Item and storage widths.
   localparam int NCOMP     = 9;
   localparam int TENSOR_W  = 48;
   localparam int ACC_W     = 64;
   localparam int IN_W      = 24;
   localparam int ELAPSED_W = 32;
   localparam int BIN_W     = 32;
   localparam int LAGCNT_W  = 8;
   localparam int LAGIDX_W  = 7;
   localparam int COMP_W    = 4;
   localparam int PASS_W    = 32;
   localparam int FILL_OUT_W = 8;
   localparam int CSR_DATA_W = 32;
   // Ring step after a long gap, sized for the largest supported lag depth.
   localparam int RMOD_W    = 10;
   localparam int RING_W    = NCOMP * TENSOR_W;
   localparam int ACC_ROW_W = NCOMP * ACC_W;

   // Item kinds.
   typedef enum logic {
      CMD_EVENT = 1'b0,
      CMD_READ  = 1'b1
   } cmd_code_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_BIN_WIDTH = 1'b0,
      CSR_LAG_COUNT = 1'b1
   } csr_index_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic                        is_read;
      logic                        push_first;
      logic [ELAPSED_W-1:0]        extra;
      logic [RMOD_W-1:0]           ring_step;
      logic signed [IN_W-1:0]      dp_x;
      logic signed [IN_W-1:0]      dp_y;
      logic signed [IN_W-1:0]      dp_z;
      logic signed [IN_W-1:0]      sep_x;
      logic signed [IN_W-1:0]      sep_y;
      logic signed [IN_W-1:0]      sep_z;
      logic [LAGIDX_W-1:0]         lag_index;
      logic [COMP_W-1:0]           component;
   } esc_cmd_type;

   // Row of a tensor element; three for codes that name no element.
   function automatic logic [1:0] comp_row(input logic [COMP_W-1:0] comp);
      logic [1:0] row;
      unique case (comp) inside
         4'd0, 4'd1, 4'd2: row = 2'd0;
         4'd3, 4'd4, 4'd5: row = 2'd1;
         4'd6, 4'd7, 4'd8: row = 2'd2;
         default:          row = 2'd3;
      endcase
      return row;
   endfunction

   // Column of a tensor element; three for codes that name no element.
   function automatic logic [1:0] comp_col(input logic [COMP_W-1:0] comp);
      logic [1:0] col;
      unique case (comp) inside
         4'd0, 4'd3, 4'd6: col = 2'd0;
         4'd1, 4'd4, 4'd7: col = 2'd1;
         4'd2, 4'd5, 4'd8: col = 2'd2;
         default:          col = 2'd3;
      endcase
      return col;
   endfunction

   // True when the element lies inside the dimensions in use.
   function automatic logic comp_in_dims(input logic [COMP_W-1:0] comp, input int dims);
      logic [1:0] row;
      logic [1:0] col;
      row = comp_row(comp);
      col = comp_col(comp);
      return (int'(row) < dims) && (int'(col) < dims);
   endfunction

endpackage

@@ rtl/esc_chan_if.sv @@
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps

interface esc_req_if;
   logic                valid;
   logic                ready;
   logic                command;
   logic [31:0]         elapsed;
   logic signed [23:0]  dp_x;
   logic signed [23:0]  dp_y;
   logic signed [23:0]  dp_z;
   logic signed [23:0]  sep_x;
   logic signed [23:0]  sep_y;
   logic signed [23:0]  sep_z;
   logic [6:0]          lag_index;
   logic [3:0]          component;

   modport source (output valid, command, elapsed, dp_x, dp_y, dp_z, sep_x, sep_y, sep_z,
                   lag_index, component, input ready);
   modport sink   (input valid, command, elapsed, dp_x, dp_y, dp_z, sep_x, sep_y, sep_z,
                   lag_index, component, output ready);
endinterface

interface esc_rsp_if;
   logic                valid;
   logic                ready;
   logic [63:0]         square_sum;
   logic signed [63:0]  trace_total;
   logic [31:0]         pass_count;
   logic [7:0]          bins_stored;

   modport source (output valid, square_sum, trace_total, pass_count, bins_stored,
                   input ready);
   modport sink   (input valid, square_sum, trace_total, pass_count, bins_stored,
                   output ready);
endinterface

@@ rtl/esc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module esc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/esc_front.sv @@
// Front end: accepts items, tracks time residue and splits elapsed time into bins.
`timescale 1ns / 1ps

module esc_front
   import esc_pkg::*;
#(
   parameter int MAX_LAG = 128
) (
   input  logic               clock,
   input  logic               reset,
   esc_req_if.sink            req_chan,
   input  logic [BIN_W-1:0]   bin_width,
   input  logic               clear_done,
   input  logic               q_full,
   output logic               q_push,
   output esc_cmd_type        q_cmd
);

   localparam int MW  = $clog2(MAX_LAG);
   localparam int MW1 = MW + 1;
   localparam int DIV_STEPS = ELAPSED_W;
   localparam int CW  = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_DIV  = 2'b10
   } front_state_type;

   front_state_type          state_ff, state_in;
   logic [BIN_W-1:0]         residue_ff, residue_in;
   logic [ELAPSED_W-1:0]     dividend_ff, dividend_in;
   logic [BIN_W-1:0]         rem_ff, rem_in;
   logic [ELAPSED_W-1:0]     quo_ff, quo_in;
   logic [MW-1:0]            mod_ff, mod_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   esc_cmd_type              item_ff, item_in;

   logic                     accept;
   logic [BIN_W-1:0]         bw_eff;
   logic [BIN_W:0]           total;
   logic                     short_gap;
   logic [BIN_W:0]           div_r;
   logic                     div_ge;
   logic [MW1-1:0]           mod_t;
   esc_cmd_type              req_cmd;

   assign req_chan.ready = (state_ff == F_IDLE) && !q_full && clear_done;
   assign accept = req_chan.valid && req_chan.ready;

   // Item fields as a command word.
   always_comb begin
      req_cmd            = '0;
      req_cmd.is_read    = (req_chan.command == CMD_READ);
      req_cmd.dp_x       = req_chan.dp_x;
      req_cmd.dp_y       = req_chan.dp_y;
      req_cmd.dp_z       = req_chan.dp_z;
      req_cmd.sep_x      = req_chan.sep_x;
      req_cmd.sep_y      = req_chan.sep_y;
      req_cmd.sep_z      = req_chan.sep_z;
      req_cmd.lag_index  = req_chan.lag_index;
      req_cmd.component  = req_chan.component;
   end

   // Time bookkeeping: a zero bin width acts as one.
   assign bw_eff    = (bin_width == '0) ? BIN_W'(1) : bin_width;
   assign total     = {1'b0, residue_ff} + {1'b0, req_chan.elapsed};
   assign short_gap = total < {1'b0, bw_eff};

   // One restoring division step, with the quotient also reduced modulo the ring depth.
   assign div_r  = {rem_ff, dividend_ff[ELAPSED_W-1]};
   assign div_ge = div_r >= {1'b0, bw_eff};
   assign mod_t  = {mod_ff, div_ge};

   always_comb begin
      state_in    = state_ff;
      residue_in  = residue_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      mod_in      = mod_ff;
      cnt_in      = cnt_ff;
      item_in     = item_ff;
      q_push      = 1'b0;
      q_cmd       = req_cmd;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               item_in = req_cmd;
               if (req_cmd.is_read) begin
                  q_push = 1'b1;
               end else if (short_gap) begin
                  residue_in = total[BIN_W-1:0];
                  q_push     = 1'b1;
               end else begin
                  dividend_in = ELAPSED_W'(total - {1'b0, bw_eff});
                  rem_in      = '0;
                  quo_in      = '0;
                  mod_in      = '0;
                  cnt_in      = '0;
                  state_in    = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (cnt_ff != CW'(DIV_STEPS)) begin
               rem_in      = div_ge ? BIN_W'(div_r - {1'b0, bw_eff}) : div_r[BIN_W-1:0];
               quo_in      = {quo_ff[ELAPSED_W-2:0], div_ge};
               mod_in      = (mod_t >= MW1'(MAX_LAG)) ? MW'(mod_t - MW1'(MAX_LAG))
                                                      : mod_t[MW-1:0];
               dividend_in = {dividend_ff[ELAPSED_W-2:0], 1'b0};
               cnt_in      = cnt_ff + CW'(1);
            end else if (!q_full) begin
               q_cmd            = item_ff;
               q_cmd.push_first = 1'b1;
               q_cmd.extra      = quo_ff;
               q_cmd.ring_step  = RMOD_W'(mod_ff);
               q_push           = 1'b1;
               residue_in       = rem_ff;
               state_in         = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         residue_ff <= '0;
      end else begin
         state_ff   <= state_in;
         residue_ff <= residue_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      mod_ff      <= mod_in;
      cnt_ff      <= cnt_in;
      item_ff     <= item_in;
   end

endmodule

@@ rtl/esc_queue.sv @@
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module esc_queue
   import esc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  esc_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output esc_cmd_type pop_cmd,
   output logic        not_empty
);

   esc_cmd_type ent_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_cmd   = ent_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/esc_back.sv @@
// Back end: tensor, lag ring, accumulation passes, trace sums and reads.
`timescale 1ns / 1ps

module esc_back
   import esc_pkg::*;
#(
   parameter int MAX_LAG = 128,
   parameter int DIMS    = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [LAGCNT_W-1:0] lag_count,
   input  logic                q_valid,
   input  esc_cmd_type         q_cmd,
   output logic                q_pop,
   output logic                clear_done,
   esc_rsp_if.source           rsp_chan
);

   localparam int AW = $clog2(MAX_LAG);
   localparam int NW = $clog2(MAX_LAG + 1);
   localparam int ZW = $clog2(2 * MAX_LAG + 1);
   localparam int AW1 = AW + 1;

   typedef enum logic [8:0] {
      B_CLEAR  = 9'b000000001,
      B_IDLE   = 9'b000000010,
      B_READ   = 9'b000000100,
      B_RDATA  = 9'b000001000,
      B_PUSH   = 9'b000010000,
      B_PASS   = 9'b000100000,
      B_DRAIN  = 9'b001000000,
      B_ROTATE = 9'b010000000,
      B_MUL    = 9'b100000000
   } back_state_type;

   back_state_type          state_ff;
   logic [AW-1:0]           clr_ff;
   logic [AW-1:0]           head_ff;
   logic [NW-1:0]           fill_ff;
   logic [PASS_W-1:0]       passes_ff;
   logic                    push_first_ff;
   logic [ZW-1:0]           zero_cnt_ff;
   logic [ELAPSED_W-1:0]    rest_ff;
   logic [AW-1:0]           rmod_ff;
   logic signed [IN_W-1:0]  dp_ff [3];
   logic signed [IN_W-1:0]  sep_ff [3];
   logic [LAGIDX_W-1:0]     lag_ff;
   logic [COMP_W-1:0]       comp_ff;
   logic [NW-1:0]           i_ff;
   logic [AW-1:0]           slot_ff;
   logic [COMP_W-1:0]       k_ff;
   logic signed [TENSOR_W-1:0] tensor_ff [NCOMP];
   logic signed [ACC_W-1:0]    trace_ff [NCOMP];

   // Pass pipeline: ring data, prefix sums, partial products, squares.
   logic [4:1]              v_ff;
   logic [AW-1:0]           idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic signed [ACC_W-1:0] sum_ff [NCOMP];
   logic [63:0]             hh_ff [NCOMP];
   logic [63:0]             hl_ff [NCOMP];
   logic [63:0]             ll_ff [NCOMP];
   logic [ACC_W-1:0]        sq_ff [NCOMP];

   // Result register.
   logic                    rsp_valid_ff;
   logic [ACC_W-1:0]        rsp_sq_ff;
   logic signed [ACC_W-1:0] rsp_tr_ff;
   logic [PASS_W-1:0]       rsp_pass_ff;
   logic [FILL_OUT_W-1:0]   rsp_fill_ff;

   logic [NW-1:0]           n_used;
   logic [NW-1:0]           fill_next;
   logic [AW-1:0]           head_dec;
   logic                    push_act;
   logic [RING_W-1:0]       ring_wr_data;
   logic [RING_W-1:0]       ring_rd;
   logic [ACC_ROW_W-1:0]    acc_rd;
   logic [ACC_ROW_W-1:0]    acc_wr_data;
   logic                    acc_wr_en;
   logic [AW-1:0]           acc_wr_addr;
   logic [AW-1:0]           acc_rd_addr;
   logic [ACC_W-1:0]        acc_rd_arr [NCOMP];
   logic [ACC_W-1:0]        mag [NCOMP];
   logic [127:0]            full_sq [NCOMP];
   logic [ACC_W:0]          acc_sum [NCOMP];
   logic [ACC_W:0]          trace_sum [NCOMP];
   logic [1:0]              mul_row;
   logic [1:0]              mul_col;
   logic signed [TENSOR_W-1:0] mul_prod;
   logic signed [TENSOR_W:0]   mul_sum;
   logic [AW1-1:0]          head_rot;
   logic [PASS_W:0]         pass_add;
   logic                    pipe_busy;

   // Lags in use: zero acts as one, above the ring depth acts as the depth.
   always_comb begin
      if (lag_count == '0) begin
         n_used = NW'(1);
      end else if (32'(lag_count) > MAX_LAG) begin
         n_used = NW'(MAX_LAG);
      end else begin
         n_used = NW'(lag_count);
      end
   end

   assign fill_next  = (fill_ff < n_used) ? fill_ff + NW'(1) : fill_ff;
   assign head_dec   = (head_ff == '0) ? AW'(MAX_LAG - 1) : head_ff - AW'(1);
   assign push_act   = push_first_ff || (zero_cnt_ff != '0);
   assign pipe_busy  = |v_ff;
   assign clear_done = (state_ff != B_CLEAR);
   assign q_pop      = (state_ff == B_IDLE) && q_valid && (!q_cmd.is_read || !rsp_valid_ff);

   // Ring row written on a push: the finished tensor or an empty bin.
   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         ring_wr_data[c*TENSOR_W +: TENSOR_W] = push_first_ff ? tensor_ff[c] : '0;
      end
   end

   esc_ram #(
      .WIDTH (RING_W),
      .DEPTH (MAX_LAG)
   ) u_ring (
      .clock   (clock),
      .wr_en   ((state_ff == B_PUSH) && push_act),
      .wr_addr (head_dec),
      .wr_data (ring_wr_data),
      .rd_addr (slot_ff),
      .rd_data (ring_rd)
   );

   // Accumulator port: clearing sweep, pass write-back and item reads.
   assign acc_rd_addr = (state_ff == B_READ) ? AW'(lag_ff) : idx3_ff;
   assign acc_wr_en   = (state_ff == B_CLEAR) || v_ff[4];
   assign acc_wr_addr = (state_ff == B_CLEAR) ? clr_ff : idx4_ff;

   esc_ram #(
      .WIDTH (ACC_ROW_W),
      .DEPTH (MAX_LAG)
   ) u_accum (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd)
   );

   // Per-lane arithmetic of the pass pipeline and the trace update.
   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         acc_rd_arr[c] = acc_rd[c*ACC_W +: ACC_W];
         mag[c]        = sum_ff[c][ACC_W-1] ? ACC_W'(-sum_ff[c]) : ACC_W'(sum_ff[c]);
         full_sq[c]    = {hh_ff[c], 64'b0} + ({64'b0, hl_ff[c]} << 33) + {64'b0, ll_ff[c]};
         acc_sum[c]    = {1'b0, acc_rd_arr[c]} + {1'b0, sq_ff[c]};
         acc_wr_data[c*ACC_W +: ACC_W] = (state_ff == B_CLEAR) ? '0 :
                                         (acc_sum[c][ACC_W] ? '1 : acc_sum[c][ACC_W-1:0]);
         trace_sum[c]  = {trace_ff[c][ACC_W-1], trace_ff[c]} +
                         {{(ACC_W-TENSOR_W+1){tensor_ff[c][TENSOR_W-1]}}, tensor_ff[c]};
      end
   end

   // One tensor element per cycle of the outer product.
   assign mul_row  = comp_row(k_ff);
   assign mul_col  = comp_col(k_ff);
   assign mul_prod = dp_ff[mul_row] * sep_ff[mul_col];
   assign mul_sum  = {tensor_ff[k_ff][TENSOR_W-1], tensor_ff[k_ff]} +
                     {mul_prod[TENSOR_W-1], mul_prod};

   // Head rotation and pass count after a long gap.
   assign head_rot = {1'b0, head_ff} - {1'b0, rmod_ff};
   assign pass_add = {1'b0, passes_ff} + {1'b0, rest_ff};

   // Control sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         passes_ff    <= '0;
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NCOMP; c++) begin
            tensor_ff[c] <= '0;
            trace_ff[c]  <= '0;
         end
      end else begin
         v_ff[4:2] <= v_ff[3:1];
         v_ff[1]   <= 1'b0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MAX_LAG - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (q_pop) begin
                  state_ff <= q_cmd.is_read ? B_READ : B_PUSH;
               end
            end
            B_READ: state_ff <= B_RDATA;
            B_RDATA: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= B_IDLE;
            end
            B_PUSH: begin
               if (push_act) begin
                  head_ff <= head_dec;
                  fill_ff <= fill_next;
                  if (push_first_ff) begin
                     for (int c = 0; c < NCOMP; c++) begin
                        tensor_ff[c] <= '0;
                        if (trace_sum[c][ACC_W] != trace_sum[c][ACC_W-1]) begin
                           trace_ff[c] <= trace_sum[c][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                              : {1'b0, {(ACC_W-1){1'b1}}};
                        end else begin
                           trace_ff[c] <= trace_sum[c][ACC_W-1:0];
                        end
                     end
                  end
                  if (fill_next >= n_used) begin
                     passes_ff <= (passes_ff == '1) ? passes_ff : passes_ff + PASS_W'(1);
                     state_ff  <= B_PASS;
                  end
               end else begin
                  state_ff <= B_ROTATE;
               end
            end
            B_PASS: begin
               v_ff[1] <= 1'b1;
               if (i_ff == n_used - NW'(1)) begin
                  state_ff <= B_DRAIN;
               end
            end
            B_DRAIN: begin
               if (!pipe_busy) begin
                  state_ff <= B_PUSH;
               end
            end
            B_ROTATE: begin
               passes_ff <= pass_add[PASS_W] ? '1 : pass_add[PASS_W-1:0];
               head_ff   <= head_rot[AW] ? AW'(head_rot + AW1'(MAX_LAG)) : head_rot[AW-1:0];
               state_ff  <= B_MUL;
            end
            B_MUL: begin
               if (comp_in_dims(k_ff, DIMS)) begin
                  if (mul_sum[TENSOR_W] != mul_sum[TENSOR_W-1]) begin
                     tensor_ff[k_ff] <= mul_sum[TENSOR_W] ? {1'b1, {(TENSOR_W-1){1'b0}}}
                                                          : {1'b0, {(TENSOR_W-1){1'b1}}};
                  end else begin
                     tensor_ff[k_ff] <= mul_sum[TENSOR_W-1:0];
                  end
               end
               if (k_ff == COMP_W'(NCOMP - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // Command fields, pass counters and the pass pipeline data path.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         push_first_ff <= q_cmd.push_first;
         // The head only turns for bins beyond the ones that are pushed.
         if (q_cmd.extra > ELAPSED_W'(2 * MAX_LAG)) begin
            zero_cnt_ff <= ZW'(2 * MAX_LAG);
            rest_ff     <= q_cmd.extra - ELAPSED_W'(2 * MAX_LAG);
            rmod_ff     <= AW'(q_cmd.ring_step);
         end else begin
            zero_cnt_ff <= ZW'(q_cmd.extra);
            rest_ff     <= '0;
            rmod_ff     <= '0;
         end
         dp_ff[0]  <= q_cmd.dp_x;
         dp_ff[1]  <= q_cmd.dp_y;
         dp_ff[2]  <= q_cmd.dp_z;
         sep_ff[0] <= q_cmd.sep_x;
         sep_ff[1] <= q_cmd.sep_y;
         sep_ff[2] <= q_cmd.sep_z;
         lag_ff    <= q_cmd.lag_index;
         comp_ff   <= q_cmd.component;
      end
      if ((state_ff == B_PUSH) && push_act) begin
         if (push_first_ff) begin
            push_first_ff <= 1'b0;
         end else begin
            zero_cnt_ff <= zero_cnt_ff - ZW'(1);
         end
         i_ff    <= '0;
         slot_ff <= head_dec;
         for (int c = 0; c < NCOMP; c++) begin
            sum_ff[c] <= '0;
         end
      end
      if (state_ff == B_PASS) begin
         i_ff    <= i_ff + NW'(1);
         slot_ff <= (slot_ff == AW'(MAX_LAG - 1)) ? '0 : slot_ff + AW'(1);
         idx1_ff <= AW'(i_ff);
      end
      if (state_ff == B_ROTATE) begin
         k_ff <= '0;
      end else if (state_ff == B_MUL) begin
         k_ff <= k_ff + COMP_W'(1);
      end
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      for (int c = 0; c < NCOMP; c++) begin
         if (v_ff[1]) begin
            sum_ff[c] <= sum_ff[c] + {{(ACC_W-TENSOR_W){ring_rd[c*TENSOR_W+TENSOR_W-1]}},
                                      ring_rd[c*TENSOR_W +: TENSOR_W]};
         end
         hh_ff[c] <= mag[c][63:32] * mag[c][63:32];
         hl_ff[c] <= mag[c][63:32] * mag[c][31:0];
         ll_ff[c] <= mag[c][31:0] * mag[c][31:0];
         sq_ff[c] <= (full_sq[c][127:112] != '0) ? '1 : full_sq[c][111:48];
      end
      // Result fields for a read item.
      if (state_ff == B_RDATA) begin
         rsp_sq_ff   <= (comp_ff < COMP_W'(NCOMP) && 32'(lag_ff) < MAX_LAG &&
                         comp_in_dims(comp_ff, DIMS)) ? acc_rd_arr[comp_ff] : '0;
         rsp_tr_ff   <= (comp_ff < COMP_W'(NCOMP)) ? trace_ff[comp_ff] : '0;
         rsp_pass_ff <= passes_ff;
         rsp_fill_ff <= FILL_OUT_W'(fill_ff);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.square_sum  = rsp_sq_ff;
   assign rsp_chan.trace_total = rsp_tr_ff;
   assign rsp_chan.pass_count  = rsp_pass_ff;
   assign rsp_chan.bins_stored = rsp_fill_ff;

   // The pass pipeline only carries data while a pass runs or drains.
   a_pipe_in_pass: assert property (@(posedge clock) disable iff (reset)
      v_ff[4] |-> (state_ff == B_PASS || state_ff == B_DRAIN))
      else $error("pass pipeline active outside a pass");

   // The fill level never passes the ring depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_LAG)
      else $error("fill level above ring depth");

   // A read result is only formed into a free result register.
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RDATA) |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // No command is taken during the clearing sweep.
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> !q_pop)
      else $error("command taken during clearing sweep");

endmodule

@@ rtl/einstein_stress_correlator_unit.sv @@
// Top level of the stress correlator: configuration registers and block wiring.
`timescale 1ns / 1ps
//
// Items arrive on req_chan (valid/ready). An event item (command 0) advances
// time by elapsed and then adds dp x sep to the impulse tensor; it returns
// nothing. A read item (command 1) returns one result on rsp_chan: the square
// accumulator for lag_index and component, the trace sum, the pass count and
// the ring fill level.
// The front end takes an item while idle; an event that completes a bin then
// runs through the restoring bin divider before it is queued, and the front
// takes no new item meanwhile. Each pushed bin that triggers a pass in the back
// end walks the lags in use one lag per cycle through the ring and accumulator
// memories with nine lanes in parallel.
// At most 2*MAX_LAG + 1 bins are pushed per event.
// A two-entry queue between the ends lets the front take new items while the
// back works or a result waits; a stalled rsp_chan holds its result and blocks
// further reads and the items queued behind them.
// After reset the accumulator memory is cleared in a sweep over its MAX_LAG rows,
// during which no item is accepted. Configuration writes are taken at any time.

module einstein_stress_correlator_unit
   import esc_pkg::*;
#(
   parameter int MAX_LAG = 128,
   parameter int DIMS    = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   esc_req_if.sink               req_chan,
   esc_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [BIN_W-1:0]    bin_width_ff;
   logic [LAGCNT_W-1:0] lag_count_ff;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   logic                clear_done;
   esc_cmd_type         q_push_cmd;
   esc_cmd_type         q_pop_cmd;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= BIN_W'(1024);
         lag_count_ff <= LAGCNT_W'(100);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIN_WIDTH: bin_width_ff <= csr_wr_data[BIN_W-1:0];
            CSR_LAG_COUNT: lag_count_ff <= csr_wr_data[LAGCNT_W-1:0];
            default:       bin_width_ff <= bin_width_ff;
         endcase
      end
   end

   esc_front #(
      .MAX_LAG (MAX_LAG)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .bin_width  (bin_width_ff),
      .clear_done (clear_done),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_push_cmd)
   );

   esc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_cmd   (q_pop_cmd),
      .not_empty (q_valid)
   );

   esc_back #(
      .MAX_LAG (MAX_LAG),
      .DIMS    (DIMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .lag_count  (lag_count_ff),
      .q_valid    (q_valid),
      .q_cmd      (q_pop_cmd),
      .q_pop      (q_pop),
      .clear_done (clear_done),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ tb/esc_score_checker.sv @@
// Checker for the stress correlator: predicts read results and compares them.
`timescale 1ns / 1ps

module esc_score_checker
   import esc_pkg::*;
#(
   parameter int MAX_LAG = 128,
   parameter int DIMS    = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   esc_req_if                    req,
   esc_rsp_if                    rsp,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    mismatches,
   output int                    outstanding
);

   localparam longint TENSOR_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint TENSOR_MIN = -TENSOR_MAX - 1;

   typedef struct {
      logic [63:0]        square_sum;
      logic signed [63:0] trace_total;
      logic [31:0]        pass_count;
      logic [7:0]         bins_stored;
   } reading_type;

   reading_type readings_due[$];

   // Predicted state of the correlator.
   longint      tensor[9];
   longint      ring[MAX_LAG][9];
   logic [63:0] square_acc[MAX_LAG][9];
   longint      trace_sum[9];
   logic [31:0] residue;
   logic [31:0] passes;
   logic [31:0] bin_width;
   logic [7:0]  lag_count;
   int          head;
   int          fill;

   initial mismatches = 0;

   function automatic int lags_in_use();
      if (lag_count == 0) return 1;
      if (lag_count > MAX_LAG) return MAX_LAG;
      return lag_count;
   endfunction

   function automatic longint add_clamped(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
      return s;
   endfunction

   // Square of a magnitude, shifted down by 48 and clamped to 64 bits.
   function automatic logic [63:0] scaled_square(logic [63:0] mag);
      logic [127:0] prod;
      prod = {64'd0, mag} * {64'd0, mag};
      prod = prod >> 48;
      if (|prod[127:64]) return '1;
      return prod[63:0];
   endfunction

   // One pass over the ring: prefix sums from newest to oldest, squares summed.
   task automatic accumulate_lags(int n);
      longint      run[9];
      logic [63:0] mag;
      logic [63:0] sq;
      logic [63:0] acc;
      int          slot;
      for (int c = 0; c < 9; c++) run[c] = 0;
      if (passes != 32'hFFFF_FFFF) passes++;
      for (int i = 0; i < n; i++) begin
         slot = (head + i) % MAX_LAG;
         for (int c = 0; c < 9; c++) begin
            run[c] += ring[slot][c];
            mag = (run[c] < 0) ? 64'(-run[c]) : 64'(run[c]);
            sq = scaled_square(mag);
            acc = square_acc[i][c] + sq;
            square_acc[i][c] = (acc < sq) ? '1 : acc;
         end
      end
   endtask

   task automatic push_bin(input longint t[9]);
      int n;
      n = lags_in_use();
      for (int c = 0; c < 9; c++) trace_sum[c] = add_clamped(trace_sum[c], t[c]);
      head = (head + MAX_LAG - 1) % MAX_LAG;
      for (int c = 0; c < 9; c++) ring[head][c] = t[c];
      if (fill < n) fill++;
      if (fill >= n) accumulate_lags(n);
   endtask

   // Time advance: the current bin closes, then whole empty bins follow.
   task automatic advance_time(logic [31:0] elapsed);
      longint unsigned bw;
      longint unsigned total;
      longint unsigned extra;
      longint unsigned done;
      longint unsigned rest;
      longint unsigned p;
      longint          zeros[9];
      for (int c = 0; c < 9; c++) zeros[c] = 0;
      bw = (bin_width == 0) ? 1 : bin_width;
      total = residue + elapsed;
      if (total < bw) begin
         residue = total[31:0];
         return;
      end
      push_bin(tensor);
      for (int c = 0; c < 9; c++) tensor[c] = 0;
      total -= bw;
      extra = total / bw;
      residue = 32'(total % bw);
      done = (extra < 2 * MAX_LAG) ? extra : 2 * MAX_LAG;
      for (longint unsigned k = 0; k < done; k++) push_bin(zeros);
      rest = extra - done;
      if (rest != 0) begin
         p = passes + rest;
         passes = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
         head = int'((head + MAX_LAG - (rest % MAX_LAG)) % MAX_LAG);
      end
   endtask

   task automatic apply_event();
      longint dp[3];
      longint sp[3];
      longint v;
      advance_time(req.elapsed);
      dp[0] = req.dp_x;  dp[1] = req.dp_y;  dp[2] = req.dp_z;
      sp[0] = req.sep_x; sp[1] = req.sep_y; sp[2] = req.sep_z;
      for (int r = 0; r < DIMS; r++) begin
         for (int c = 0; c < DIMS; c++) begin
            v = tensor[r * 3 + c] + dp[r] * sp[c];
            if (v > TENSOR_MAX) v = TENSOR_MAX;
            if (v < TENSOR_MIN) v = TENSOR_MIN;
            tensor[r * 3 + c] = v;
         end
      end
   endtask

   task automatic expect_reading();
      reading_type rd;
      int comp;
      int lag;
      comp = req.component;
      lag = req.lag_index;
      rd.square_sum = '0;
      rd.trace_total = '0;
      if (comp < 9) begin
         rd.trace_total = trace_sum[comp];
         if (lag < MAX_LAG && comp / 3 < DIMS && comp % 3 < DIMS)
            rd.square_sum = square_acc[lag][comp];
      end
      rd.pass_count = passes;
      rd.bins_stored = 8'(fill);
      readings_due.push_back(rd);
   endtask

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: MISMATCH %s got %h expected %h", $realtime, field, got, want);
      mismatches++;
   endtask

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      reading_type rd;
      if (reset) begin
         for (int c = 0; c < 9; c++) begin
            tensor[c] = 0;
            trace_sum[c] = 0;
            for (int i = 0; i < MAX_LAG; i++) begin
               ring[i][c] = 0;
               square_acc[i][c] = '0;
            end
         end
         residue = 0;
         passes = 0;
         head = 0;
         fill = 0;
         bin_width = 32'd1024;
         lag_count = 8'd100;
         readings_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (readings_due.size() == 0) begin
               $display("%0t: MISMATCH result item with nothing expected", $realtime);
               mismatches++;
            end else begin
               rd = readings_due.pop_front();
               if (rsp.square_sum !== rd.square_sum)
                  report("square_sum", rsp.square_sum, rd.square_sum);
               if (rsp.trace_total !== rd.trace_total)
                  report("trace_total", rsp.trace_total, rd.trace_total);
               if (rsp.pass_count !== rd.pass_count)
                  report("pass_count", 64'(rsp.pass_count), 64'(rd.pass_count));
               if (rsp.bins_stored !== rd.bins_stored)
                  report("bins_stored", 64'(rsp.bins_stored), 64'(rd.bins_stored));
            end
         end
         if (req.valid && req.ready) begin
            if (req.command == CMD_READ) expect_reading();
            else apply_event();
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_BIN_WIDTH) bin_width = csr_wr_data;
            else lag_count = csr_wr_data[7:0];
         end
      end
      outstanding = readings_due.size();
   end

endmodule

@@ tb/einstein_stress_correlator_unit_test.sv @@
// Top of the stress correlator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module einstein_stress_correlator_unit_test;
   import esc_pkg::*;

   localparam int SETTLE_CYCLES = 150000;
   localparam int PHASES = 6;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int   mismatches;
   int   outstanding;
   int   events_sent;
   int   reads_sent;
   bit   calm;

   logic [31:0] phase_bin_width[PHASES] = '{32'd16, 32'd0, 32'hFFFF_FFFF, 32'd64, 32'd8,
                                            32'd100};
   logic [31:0] phase_lag_count[PHASES] = '{32'd4, 32'd1, 32'd128, 32'd0, 32'd255, 32'd16};

   esc_req_if req();
   esc_rsp_if rsp();

   einstein_stress_correlator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req),
      .rsp_chan   (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   esc_score_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   // Free-running 100 MHz clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The result side stalls at random except during the calm stretch.
   initial rsp.ready = 1'b0;
   always @(negedge clock) begin
      rsp.ready = calm || ($urandom_range(0, 99) >= 15);
   end

   // Overall time limit.
   initial begin
      repeat (50) #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Waits until every read has answered and any bin work has drained.
   task automatic settle();
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Hands one item to the block and returns at the falling edge after acceptance.
   task automatic put_item(logic cmd, logic [31:0] el, logic [23:0] dx, logic [23:0] dy,
                           logic [23:0] dz, logic [23:0] sx, logic [23:0] sy,
                           logic [23:0] sz, logic [6:0] lag, logic [3:0] comp);
      if (!calm && $urandom_range(0, 99) < 15) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req.valid = 1'b1;
      req.command = cmd;
      req.elapsed = el;
      req.dp_x = dx;  req.dp_y = dy;  req.dp_z = dz;
      req.sep_x = sx; req.sep_y = sy; req.sep_z = sz;
      req.lag_index = lag;
      req.component = comp;
      // Ready only moves at the rising edge, so it is looked at between edges.
      while (!req.ready) @(negedge clock);
      @(negedge clock);
      if (cmd == CMD_READ) reads_sent++;
      else events_sent++;
   endtask

   task automatic put_event(logic [31:0] el, logic [23:0] dx, logic [23:0] dy,
                            logic [23:0] dz, logic [23:0] sx, logic [23:0] sy,
                            logic [23:0] sz);
      put_item(CMD_EVENT, el, dx, dy, dz, sx, sy, sz, 7'($urandom), 4'($urandom));
   endtask

   task automatic put_read(logic [6:0] lag, logic [3:0] comp);
      put_item(CMD_READ, $urandom, 24'($urandom), 24'($urandom), 24'($urandom),
               24'($urandom), 24'($urandom), 24'($urandom), lag, comp);
   endtask

   // A Q8.16 value: extremes, small magnitudes or anything.
   function automatic logic [23:0] pick_q();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 3))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            default: return 24'hFFFFFF;
         endcase
      end
      if (r < 65) return 24'($signed(13'($urandom)));
      return 24'($urandom);
   endfunction

   // Elapsed time, mostly within a few bins, seldom a long gap.
   function automatic logic [31:0] pick_elapsed(logic [31:0] bw);
      longint unsigned unit_len;
      longint unsigned v;
      int r;
      unit_len = (bw == 0) ? 1 : bw;
      r = $urandom_range(0, 99);
      if (r < 60) v = $urandom % unit_len;
      else if (r < 97) v = unit_len * $urandom_range(1, 3);
      else if (r < 99) v = unit_len * $urandom_range(4, 300);
      else v = $urandom;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      return v[31:0];
   endfunction

   task automatic random_items(int count, logic [31:0] bw, int calm_from, int calm_to);
      for (int k = 0; k < count; k++) begin
         calm = (k >= calm_from && k < calm_to);
         if ($urandom_range(0, 99) < 30)
            put_read(7'($urandom),
                     ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8)) : 4'($urandom));
         else
            put_event(pick_elapsed(bw), pick_q(), pick_q(), pick_q(), pick_q(), pick_q(),
                      pick_q());
      end
      calm = 1'b0;
   endtask

   initial begin
      calm = 1'b0;
      events_sent = 0;
      reads_sent = 0;
      req.valid = 1'b0;
      req.command = CMD_EVENT;
      req.elapsed = '0;
      req.dp_x = '0;  req.dp_y = '0;  req.dp_z = '0;
      req.sep_x = '0; req.sep_y = '0; req.sep_z = '0;
      req.lag_index = '0;
      req.component = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_BIN_WIDTH;
      csr_wr_data = '0;
      reset = 1'b1;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed part: extremes, tensor clamping, bin edges and odd reads.
      write_reg(CSR_BIN_WIDTH, phase_bin_width[0]);
      write_reg(CSR_LAG_COUNT, phase_lag_count[0]);
      put_event(32'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      put_event(32'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      put_event(32'd15, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                24'h7FFFFF);
      put_event(32'd1, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                24'h800000);
      put_event(32'd16, 24'h800000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h010000,
                24'h000000);
      put_event(32'd48, 24'h010000, 24'hFF0000, 24'h008000, 24'h020000, 24'h000100,
                24'hFFFF00);
      put_read(7'd0, 4'd0);
      put_read(7'd3, 4'd4);
      put_read(7'd127, 4'd8);
      put_read(7'd1, 4'd9);
      put_read(7'd2, 4'd15);
      put_event(32'd17, 24'h000001, 24'h000002, 24'h000003, 24'h000004, 24'h000005,
                24'h000006);
      put_event(32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000, 24'h123456, 24'h654321, 24'hABCDEF,
                24'hFEDCBA);
      put_read(7'd0, 4'd0);
      put_read(7'd3, 4'd8);
      put_event(32'd5000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
                24'h000000);
      put_read(7'd1, 4'd1);
      req.valid = 1'b0;

      // Random phases over a spread of register settings.
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            settle();
            write_reg(CSR_BIN_WIDTH, phase_bin_width[ph]);
            write_reg(CSR_LAG_COUNT, phase_lag_count[ph]);
         end
         random_items(250, phase_bin_width[ph], (ph == 2) ? 40 : 0, (ph == 2) ? 200 : 0);
         req.valid = 1'b0;
      end

      settle();
      $display("Sent %0d event items and %0d read items over %0d register settings.",
               events_sent, reads_sent, PHASES);
      $display("Bin widths ran from zero to the 32-bit maximum, lag counts from 0 to 255.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
